// ===== hdl/mlmd_pkg.sv =====
package mlmd_pkg;

    localparam logic [1:0] CMD_HEADER  = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_FINISH  = 2'd2;

    localparam logic [1:0] KIND_META = 2'd1;
    localparam logic [1:0] KIND_CC   = 2'd2;

    localparam logic [7:0] META_TEXT      = 8'h01;
    localparam logic [7:0] META_LYRIC     = 8'h05;
    localparam logic [7:0] META_MARKER    = 8'h06;
    localparam logic [7:0] META_CUE_POINT = 8'h07;

    localparam logic [6:0] CC_LOOP_111   = 7'd111;
    localparam logic [6:0] CC_LOOP_START = 7'd116;
    localparam logic [6:0] CC_LOOP_END   = 7'd117;

    localparam logic [31:0] NONE_TICK = 32'hFFFF_FFFF;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_TEXT = 2'd1;
    localparam logic [1:0] SRC_CC111 = 2'd2;
    localparam logic [1:0] SRC_CC116 = 2'd3;

    localparam logic [2:0] OP_DROP      = 3'd0;
    localparam logic [2:0] OP_HDR_OTHER = 3'd1;
    localparam logic [2:0] OP_HDR_TEXT  = 3'd2;
    localparam logic [2:0] OP_HDR_CC111 = 3'd3;
    localparam logic [2:0] OP_HDR_CC116 = 3'd4;
    localparam logic [2:0] OP_HDR_CC117 = 3'd5;
    localparam logic [2:0] OP_BYTE      = 3'd6;
    localparam logic [2:0] OP_FINISH    = 3'd7;

    localparam int unsigned WIN_BYTES = 10;

    localparam logic [71:0] PAT_LOOPSTART  = "loopstart";
    localparam logic [79:0] PAT_LOOP_START = "loop start";
    localparam logic [79:0] PAT_LOOP_USTART = {"loop", "_start"};
    localparam logic [79:0] PAT_LOOP_BEGIN = "loop begin";
    localparam logic [55:0] PAT_LOOPEND    = "loopend";
    localparam logic [63:0] PAT_LOOP_END   = "loop end";
    localparam logic [63:0] PAT_LOOP_UEND  = {"loop", "_end"};

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] event_tick;
        logic [1:0]  event_kind;
        logic [7:0]  meta_kind;
        logic [6:0]  controller_number;
        logic [7:0]  payload_byte;
        logic        payload_last;
    } in_item_t;

    typedef struct packed {
        logic        loop_found;
        logic [31:0] loop_start_tick;
        logic [31:0] loop_end_tick;
        logic [1:0]  marker_source;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] tick;
        logic [7:0]  data;
        logic        last;
    } op_t;

endpackage

// ===== hdl/mlmd_front.sv =====
module mlmd_front
    import mlmd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     op_valid,
    output op_t      op,
    input  logic     op_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    op_t             class_op;
    logic            wr_en;
    logic            rd_en;
    op_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        class_op.tick = item.event_tick;
        class_op.last = item.payload_last;
        class_op.data = item.payload_byte;
        if (item.payload_byte >= "A" && item.payload_byte <= "Z")
        begin
            class_op.data = item.payload_byte + 8'd32;
        end
        unique case (item.command)
            CMD_HEADER:
            begin
                if (item.event_kind == KIND_META &&
                    item.meta_kind inside {META_TEXT, META_LYRIC, META_MARKER, META_CUE_POINT})
                begin
                    class_op.code = OP_HDR_TEXT;
                end
                else if (item.event_kind == KIND_CC && item.controller_number == CC_LOOP_111)
                begin
                    class_op.code = OP_HDR_CC111;
                end
                else if (item.event_kind == KIND_CC && item.controller_number == CC_LOOP_START)
                begin
                    class_op.code = OP_HDR_CC116;
                end
                else if (item.event_kind == KIND_CC && item.controller_number == CC_LOOP_END)
                begin
                    class_op.code = OP_HDR_CC117;
                end
                else
                begin
                    class_op.code = OP_HDR_OTHER;
                end
            end
            CMD_PAYLOAD: class_op.code = OP_BYTE;
            CMD_FINISH:  class_op.code = OP_FINISH;
            default:     class_op.code = OP_DROP;
        endcase
    end

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign op_valid = (count_reg != '0);
    assign op       = mem[rd_ptr_reg];
    assign wr_en    = push && !full && (class_op.code != OP_DROP);
    assign rd_en    = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= class_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/mlmd_back.sv =====
module mlmd_back
    import mlmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    input  op_t       op,
    output logic      op_ready,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic [31:0] song_end_reg, song_end_next;
    logic [31:0] text_start_reg, text_start_next;
    logic [31:0] text_end_reg, text_end_next;
    logic        have_start_reg, have_start_next;
    logic        have_end_reg, have_end_next;
    logic [31:0] cc111_reg, cc111_next;
    logic [31:0] cc116_reg, cc116_next;
    logic [31:0] cc117_reg, cc117_next;
    logic [8*WIN_BYTES-1:0] win_reg, win_next;
    logic        hit_start_reg, hit_start_next;
    logic        hit_end_reg, hit_end_next;
    logic        is_text_reg, is_text_next;
    logic [31:0] cur_tick_reg, cur_tick_next;
    logic        res_valid_reg, res_valid_next;
    out_item_t   res_reg, res_next;

    logic [8*WIN_BYTES-1:0] win_shift;
    logic        match_start;
    logic        match_end;
    logic        hs;
    logic        he;
    logic        take;
    logic        pop_ok;
    out_item_t   report;

    assign pop_ok   = pop && res_valid_reg;
    assign op_ready = (op.code != OP_FINISH) || !res_valid_reg || pop;
    assign take     = op_valid && op_ready;
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    assign win_shift   = {win_reg[8*WIN_BYTES-9:0], op.data};
    assign match_start = (win_shift[71:0] == PAT_LOOPSTART) ||
                         (win_shift[79:0] == PAT_LOOP_START) ||
                         (win_shift[79:0] == PAT_LOOP_USTART) ||
                         (win_shift[79:0] == PAT_LOOP_BEGIN);
    assign match_end   = (win_shift[55:0] == PAT_LOOPEND) ||
                         (win_shift[63:0] == PAT_LOOP_END) ||
                         (win_shift[63:0] == PAT_LOOP_UEND);
    assign hs = hit_start_reg || match_start;
    assign he = hit_end_reg || match_end;

    always_comb
    begin
        report = '0;
        if (have_start_reg && have_end_reg && text_start_reg < text_end_reg)
        begin
            report.loop_found      = 1'b1;
            report.loop_start_tick = text_start_reg;
            report.loop_end_tick   = text_end_reg;
            report.marker_source   = SRC_TEXT;
        end
        else if (cc111_reg != NONE_TICK && cc111_reg < song_end_reg)
        begin
            report.loop_found      = 1'b1;
            report.loop_start_tick = cc111_reg;
            report.loop_end_tick   = song_end_reg;
            report.marker_source   = SRC_CC111;
        end
        else if (cc116_reg != NONE_TICK && cc117_reg != NONE_TICK && cc116_reg < cc117_reg)
        begin
            report.loop_found      = 1'b1;
            report.loop_start_tick = cc116_reg;
            report.loop_end_tick   = cc117_reg;
            report.marker_source   = SRC_CC116;
        end
    end

    always_comb
    begin
        song_end_next   = song_end_reg;
        text_start_next = text_start_reg;
        text_end_next   = text_end_reg;
        have_start_next = have_start_reg;
        have_end_next   = have_end_reg;
        cc111_next      = cc111_reg;
        cc116_next      = cc116_reg;
        cc117_next      = cc117_reg;
        win_next        = win_reg;
        hit_start_next  = hit_start_reg;
        hit_end_next    = hit_end_reg;
        is_text_next    = is_text_reg;
        cur_tick_next   = cur_tick_reg;
        res_valid_next  = res_valid_reg && !pop_ok;
        res_next        = res_reg;

        if (take)
        begin
            unique case (op.code) inside
                OP_HDR_OTHER, OP_HDR_TEXT, OP_HDR_CC111, OP_HDR_CC116, OP_HDR_CC117:
                begin
                    if (op.tick > song_end_reg)
                    begin
                        song_end_next = op.tick;
                    end
                    is_text_next = 1'b0;
                    if (op.code == OP_HDR_TEXT)
                    begin
                        is_text_next   = 1'b1;
                        cur_tick_next  = op.tick;
                        win_next       = '0;
                        hit_start_next = 1'b0;
                        hit_end_next   = 1'b0;
                    end
                    if (op.code == OP_HDR_CC111 && op.tick < cc111_reg)
                    begin
                        cc111_next = op.tick;
                    end
                    if (op.code == OP_HDR_CC116 && op.tick < cc116_reg)
                    begin
                        cc116_next = op.tick;
                    end
                    if (op.code == OP_HDR_CC117 && op.tick < cc117_reg)
                    begin
                        cc117_next = op.tick;
                    end
                end
                OP_BYTE:
                begin
                    if (is_text_reg)
                    begin
                        win_next       = win_shift;
                        hit_start_next = hs;
                        hit_end_next   = he;
                        if (hs && !have_start_reg)
                        begin
                            have_start_next = 1'b1;
                            text_start_next = cur_tick_reg;
                        end
                        if (he && !have_end_reg)
                        begin
                            have_end_next = 1'b1;
                            text_end_next = cur_tick_reg;
                        end
                        if (op.last)
                        begin
                            is_text_next = 1'b0;
                        end
                    end
                end
                OP_FINISH:
                begin
                    res_valid_next  = 1'b1;
                    res_next        = report;
                    song_end_next   = '0;
                    text_start_next = '0;
                    text_end_next   = '0;
                    have_start_next = 1'b0;
                    have_end_next   = 1'b0;
                    cc111_next      = NONE_TICK;
                    cc116_next      = NONE_TICK;
                    cc117_next      = NONE_TICK;
                    win_next        = '0;
                    hit_start_next  = 1'b0;
                    hit_end_next    = 1'b0;
                    is_text_next    = 1'b0;
                    cur_tick_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_end_reg   <= '0;
            text_start_reg <= '0;
            text_end_reg   <= '0;
            have_start_reg <= 1'b0;
            have_end_reg   <= 1'b0;
            cc111_reg      <= NONE_TICK;
            cc116_reg      <= NONE_TICK;
            cc117_reg      <= NONE_TICK;
            win_reg        <= '0;
            hit_start_reg  <= 1'b0;
            hit_end_reg    <= 1'b0;
            is_text_reg    <= 1'b0;
            cur_tick_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            song_end_reg   <= song_end_next;
            text_start_reg <= text_start_next;
            text_end_reg   <= text_end_next;
            have_start_reg <= have_start_next;
            have_end_reg   <= have_end_next;
            cc111_reg      <= cc111_next;
            cc116_reg      <= cc116_next;
            cc117_reg      <= cc117_next;
            win_reg        <= win_next;
            hit_start_reg  <= hit_start_next;
            hit_end_reg    <= hit_end_next;
            is_text_reg    <= is_text_next;
            cur_tick_reg   <= cur_tick_next;
            res_valid_reg  <= res_valid_next;
        end
    end

endmodule

// ===== hdl/midi_loop_marker_detector_top.sv =====
// MIDI loop marker detector.
// Input queue: drive item and push; a transaction completes on a clock edge with push high
// and full low. Send each event as a header transaction followed by its payload bytes
// (payload_last on the final byte), then a finish transaction to get the report.
// Result queue: while empty is low, result holds the report of the oldest finish;
// pop high with empty low completes the transaction.
// Throughput: one input transaction per cycle while full is low. Headers and payload
// bytes are absorbed in the cycle they leave the internal queue; the 10-byte text window
// compare and the 32-bit tick compares are combinational in the back end.
// A finish passes the internal queue and the output register to reach the result port.
// A stalled result queue (pop low) holds the pending report in the output register;
// headers and bytes keep flowing, and a second finish waits in the QUEUE_DEPTH-entry
// internal queue, so full rises once that queue fills.
// Reset (rst_n low) empties both queues and returns all tracked ticks and flags to their
// idle values; each finish also returns them to those values after reporting.
module midi_loop_marker_detector_top
    import mlmd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic op_valid;
    logic op_ready;
    op_t  op;

    mlmd_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready)
    );

    mlmd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== hdl/mlmd_checker.sv =====
module mlmd_checker
    import mlmd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.loop_found) |->
            (result.loop_start_tick == '0 && result.loop_end_tick == '0 &&
             result.marker_source == SRC_NONE))
        else $error("report without loop has non-zero fields");

    a_found_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.loop_found) |-> (result.loop_start_tick < result.loop_end_tick))
        else $error("loop start not before loop end");

    a_source_matches: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.loop_found == (result.marker_source != SRC_NONE)))
        else $error("marker source disagrees with loop flag");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("pending result changed while stalled");

    a_full_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled with no pending result");

endmodule

bind midi_loop_marker_detector_top mlmd_checker u_mlmd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
